### src/sedg_pkg.sv
// shared types and codes for the score event group decoder
`timescale 1ns / 1ps

package sedg_pkg;

  typedef enum logic [2:0] {
    PH_TIME,
    PH_COUNT,
    PH_TYPE,
    PH_PRESS_PITCH,
    PH_PRESS_STAFF,
    PH_RELEASE,
    PH_NUMBER,
    PH_CURSOR
  } phase_t;

  // event kinds, also the record type byte values
  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_BAR     = 3'd2;
  localparam logic [2:0] KIND_CURSOR  = 3'd3;
  localparam logic [2:0] KIND_PAGE    = 3'd4;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EMPTY      = 3'd1;
  localparam logic [2:0] ERR_DUP_BAR    = 3'd2;
  localparam logic [2:0] ERR_DUP_CURSOR = 3'd3;
  localparam logic [2:0] ERR_BAD_EDGES  = 3'd4;
  localparam logic [2:0] ERR_DUP_PAGE   = 3'd5;
  localparam logic [2:0] ERR_BAD_TYPE   = 3'd6;
  localparam logic [2:0] ERR_ORDER      = 3'd7;

  localparam int FlagBar    = 0;
  localparam int FlagCursor = 1;
  localparam int FlagPage   = 2;

  localparam int TdataW = 232;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [63:0] group_time;
    logic [7:0]  key_pitch;
    logic [7:0]  staff_index;
    logic [15:0] number_value;
    logic [31:0] box_left;
    logic [31:0] box_top;
    logic [31:0] box_width;
    logic [31:0] box_height;
    logic [2:0]  error_code;
    logic        group_last;
  } result_t;

endpackage

### src/sedg_parser.sv
// byte parser: state registers and the per-byte decode logic
`timescale 1ns / 1ps

module sedg_parser import sedg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       resync,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [3:0]  byte_cnt, byte_cnt_next;
  logic [63:0] time_acc, time_acc_next;
  logic [63:0] prev_time, prev_time_next;
  logic        have_prev, have_prev_next;
  logic [7:0]  records_left, records_left_next;
  logic [2:0]  record_type, record_type_next;
  logic [31:0] edge_left, edge_left_next;
  logic [31:0] edge_top, edge_top_next;
  logic [31:0] width_hold, width_hold_next;
  logic        bad_lr, bad_lr_next;
  logic [31:0] field_acc, field_acc_next;
  logic [7:0]  pitch_hold, pitch_hold_next;
  logic [2:0]  group_flags, group_flags_next;
  logic        halted, halted_next;

  logic [31:0] acc_shift;
  logic [3:0]  cnt_inc;
  logic [7:0]  left_dec;
  logic        fin;
  result_t     fin_res;

  assign acc_shift = {field_acc[23:0], data_byte};
  assign cnt_inc   = byte_cnt + 4'd1;
  assign left_dec  = records_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    byte_cnt_next     = byte_cnt;
    time_acc_next     = time_acc;
    prev_time_next    = prev_time;
    have_prev_next    = have_prev;
    records_left_next = records_left;
    record_type_next  = record_type;
    edge_left_next    = edge_left;
    edge_top_next     = edge_top;
    width_hold_next   = width_hold;
    bad_lr_next       = bad_lr;
    field_acc_next    = field_acc;
    pitch_hold_next   = pitch_hold;
    group_flags_next  = group_flags;
    halted_next       = halted;
    res_valid         = 1'b0;
    fin               = 1'b0;
    fin_res           = '0;
    res               = '0;

    if (resync) begin
      phase_next       = PH_TIME;
      byte_cnt_next    = '0;
      time_acc_next    = '0;
      have_prev_next   = 1'b0;
      records_left_next = '0;
      record_type_next = KIND_PRESS;
      field_acc_next   = '0;
      group_flags_next = '0;
      halted_next      = 1'b0;
    end else if (!halted) begin
      case (phase)
        PH_TIME: begin
          time_acc_next = {time_acc[55:0], data_byte};
          byte_cnt_next = cnt_inc;
          if (cnt_inc == 4'd8) begin
            byte_cnt_next    = '0;
            phase_next       = PH_COUNT;
            record_type_next = KIND_PRESS;
            if (have_prev && time_acc_next < prev_time) begin
              res_valid      = 1'b1;
              res.event_kind = KIND_PRESS;
              res.error_code = ERR_ORDER;
              halted_next    = 1'b1;
            end else begin
              prev_time_next = time_acc_next;
              have_prev_next = 1'b1;
            end
          end
        end
        PH_COUNT: begin
          if (data_byte == 8'd0) begin
            res_valid      = 1'b1;
            res.event_kind = KIND_PRESS;
            res.error_code = ERR_EMPTY;
            halted_next    = 1'b1;
          end else begin
            records_left_next = data_byte;
            group_flags_next  = '0;
            phase_next        = PH_TYPE;
          end
        end
        PH_TYPE: begin
          byte_cnt_next  = '0;
          field_acc_next = '0;
          case (data_byte)
            8'(KIND_PRESS): begin
              record_type_next = KIND_PRESS;
              phase_next       = PH_PRESS_PITCH;
            end
            8'(KIND_RELEASE): begin
              record_type_next = KIND_RELEASE;
              phase_next       = PH_RELEASE;
            end
            8'(KIND_BAR): begin
              record_type_next = KIND_BAR;
              if (group_flags[FlagBar]) begin
                res_valid      = 1'b1;
                res.event_kind = KIND_BAR;
                res.error_code = ERR_DUP_BAR;
                halted_next    = 1'b1;
              end else begin
                group_flags_next[FlagBar] = 1'b1;
                phase_next = PH_NUMBER;
              end
            end
            8'(KIND_CURSOR): begin
              record_type_next = KIND_CURSOR;
              if (group_flags[FlagCursor]) begin
                res_valid      = 1'b1;
                res.event_kind = KIND_CURSOR;
                res.error_code = ERR_DUP_CURSOR;
                halted_next    = 1'b1;
              end else begin
                group_flags_next[FlagCursor] = 1'b1;
                phase_next = PH_CURSOR;
              end
            end
            8'(KIND_PAGE): begin
              record_type_next = KIND_PAGE;
              if (group_flags[FlagPage]) begin
                res_valid      = 1'b1;
                res.event_kind = KIND_PAGE;
                res.error_code = ERR_DUP_PAGE;
                halted_next    = 1'b1;
              end else begin
                group_flags_next[FlagPage] = 1'b1;
                phase_next = PH_NUMBER;
              end
            end
            default: begin
              record_type_next = KIND_PRESS;
              res_valid        = 1'b1;
              res.event_kind   = KIND_PRESS;
              res.error_code   = ERR_BAD_TYPE;
              halted_next      = 1'b1;
            end
          endcase
        end
        PH_PRESS_PITCH: begin
          pitch_hold_next = data_byte;
          phase_next      = PH_PRESS_STAFF;
        end
        PH_PRESS_STAFF: begin
          fin                 = 1'b1;
          fin_res.event_kind  = KIND_PRESS;
          fin_res.key_pitch   = pitch_hold;
          fin_res.staff_index = data_byte;
        end
        PH_RELEASE: begin
          fin                = 1'b1;
          fin_res.event_kind = KIND_RELEASE;
          fin_res.key_pitch  = data_byte;
        end
        PH_NUMBER: begin
          field_acc_next = acc_shift;
          byte_cnt_next  = cnt_inc;
          if (cnt_inc >= 4'd2) begin
            fin                  = 1'b1;
            fin_res.event_kind   = record_type;
            fin_res.number_value = acc_shift[15:0];
          end
        end
        PH_CURSOR: begin
          field_acc_next = acc_shift;
          byte_cnt_next  = cnt_inc;
          if (byte_cnt[1:0] == 2'd3) begin
            case (byte_cnt[3:2])
              2'd0: edge_left_next = acc_shift;
              // right edge: keep the width and the ordering check for the last byte
              2'd1: begin
                bad_lr_next     = edge_left >= acc_shift;
                width_hold_next = acc_shift - edge_left;
              end
              2'd2: edge_top_next = acc_shift;
              default: begin
                if (bad_lr || edge_top >= acc_shift) begin
                  res_valid      = 1'b1;
                  res.event_kind = KIND_CURSOR;
                  res.error_code = ERR_BAD_EDGES;
                  halted_next    = 1'b1;
                end else begin
                  fin                = 1'b1;
                  fin_res.event_kind = KIND_CURSOR;
                  fin_res.box_left   = edge_left;
                  fin_res.box_top    = edge_top;
                  fin_res.box_width  = width_hold;
                  fin_res.box_height = acc_shift - edge_top;
                end
              end
            endcase
          end
        end
        default: begin
          phase_next    = PH_TIME;
          byte_cnt_next = '0;
        end
      endcase

      if (fin) begin
        res_valid         = 1'b1;
        res               = fin_res;
        records_left_next = left_dec;
        byte_cnt_next     = '0;
        field_acc_next    = '0;
        res.group_last    = (left_dec == 8'd0);
        if (left_dec == 8'd0) begin
          // page change with no cursor box in the same group
          if (group_flags[FlagPage] && !group_flags[FlagCursor]) begin
            res.error_code = ERR_ORDER;
            halted_next    = 1'b1;
          end
          group_flags_next = '0;
          phase_next       = PH_TIME;
        end else begin
          phase_next = PH_TYPE;
        end
      end
      res.group_time = time_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TIME;
      byte_cnt     <= '0;
      time_acc     <= '0;
      have_prev    <= 1'b0;
      records_left <= '0;
      record_type  <= KIND_PRESS;
      field_acc    <= '0;
      group_flags  <= '0;
      halted       <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      byte_cnt     <= byte_cnt_next;
      time_acc     <= time_acc_next;
      have_prev    <= have_prev_next;
      records_left <= records_left_next;
      record_type  <= record_type_next;
      field_acc    <= field_acc_next;
      group_flags  <= group_flags_next;
      halted       <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prev_time  <= prev_time_next;
      edge_left  <= edge_left_next;
      edge_top   <= edge_top_next;
      width_hold <= width_hold_next;
      bad_lr     <= bad_lr_next;
      pitch_hold <= pitch_hold_next;
    end
  end

endmodule

### src/sedg_out_stage.sv
// result register and output stream packing
`timescale 1ns / 1ps

module sedg_out_stage import sedg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  result_t           res,
  output logic              can_take,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // event_kind, group_time, key_pitch, staff_index, number_value, box_left,
  // box_top, box_width, box_height, error_code, zero pad
  output logic [TdataW-1:0] m_axis_tdata,
  output logic              m_axis_tlast
);

  logic    out_valid;
  result_t out_res;

  assign can_take = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.group_last;
  assign m_axis_tdata  = {2'b00, out_res.error_code, out_res.box_height, out_res.box_width,
                          out_res.box_top, out_res.box_left, out_res.number_value,
                          out_res.staff_index, out_res.key_pitch, out_res.group_time,
                          out_res.event_kind};

endmodule

### src/score_event_group_decoder.sv
// top level: input register, byte parser and result register
`timescale 1ns / 1ps
// one byte per cycle unless the output stalls; each result is driven from a register
// the stage between the input register and the result register does one byte's decode
// when the result register is full and not being taken, the input register holds
// rst clears the parser to expect a new group's time bytes with no time history

module score_event_group_decoder import sedg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // data_byte
  input  logic              s_axis_tuser,   // resync
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // event_kind, group_time, key_pitch, staff_index, number_value, box_left,
  // box_top, box_width, box_height, error_code, zero pad
  output logic [TdataW-1:0] m_axis_tdata,
  output logic              m_axis_tlast    // group_last
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_resync;
  logic       step;
  logic       can_take;
  logic       res_valid;
  result_t    res;

  assign step          = in_valid && can_take;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte   <= s_axis_tdata;
      in_resync <= s_axis_tuser;
    end
  end

  sedg_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .resync    (in_resync),
    .res_valid (res_valid),
    .res       (res)
  );

  sedg_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .res           (res),
    .can_take      (can_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
